// ===== sv/drt_pkg.sv =====
// Package of shared widths, command codes and the table entry layout.
`default_nettype none
package drt_pkg;

	localparam int CMD_W      = 3;
	localparam int KEY_W      = 10;
	localparam int ID_W       = 32;
	localparam int BATCH_W    = 32;
	localparam int THREAD_W   = 5;
	localparam int MASK_W     = 32;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 3;

	// Threads that the aborted mask covers; higher thread numbers never count as aborted.
	localparam int THREADS    = 32;

	localparam int TABLE_KEYS_DEF = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESERVE_READ  = 3'd0,
		CMD_RESERVE_WRITE = 3'd1,
		CMD_CHECK_WAW     = 3'd2,
		CMD_CHECK_RAW     = 3'd3,
		CMD_CHECK_WAR     = 3'd4
	} cmd_t;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_ABORTED_MASK = 1'b0,
		REG_NONE         = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ID_W-1:0]     w_id;
		logic [BATCH_W-1:0]  w_batch;
		logic [THREAD_W-1:0] w_thread;
		logic [ID_W-1:0]     r_id;
		logic [BATCH_W-1:0]  r_batch;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== sv/drt_if.sv =====
// Valid/ready channel interfaces for request items and result items.
`default_nettype none
interface drt_req_if;
	import drt_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [KEY_W-1:0]    key;
	logic [ID_W-1:0]     txn_id;
	logic [BATCH_W-1:0]  batch_num;
	logic [THREAD_W-1:0] worker;
	modport source (output valid, cmd, key, txn_id, batch_num, worker, input ready);
	modport sink (input valid, cmd, key, txn_id, batch_num, worker, output ready);
endinterface

interface drt_rsp_if;
	logic valid;
	logic ready;
	logic reserved;
	logic conflict;
	modport source (output valid, reserved, conflict, input ready);
	modport sink (input valid, reserved, conflict, output ready);
endinterface
`default_nettype wire

// ===== sv/drt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module drt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/deterministic_reservation_table_top.sv =====
// Top level of the deterministic reservation table: entry RAM, pipeline and register port.
`default_nettype none
// The block keeps one reservation entry per key (write owner id, batch and thread, read
// owner id and batch) in a single RAM of TABLE_KEYS entries with a registered read. An
// item is accepted with the RAM read of its key; once it sits in stage 1 and the output
// register is free, the entry is checked or updated, written back and the result item is
// loaded into the output register. The sustained rate is one item per clock while results
// are taken, also for the same key in consecutive items, since the last write is forwarded
// over the RAM read. A new item is taken while a result waits, as long as the single
// pipeline stage is empty or can move on; while the result register is full and not
// taken, the stage holds. After reset a clearing pass writes zeros into every entry, one
// entry per cycle; req.ready stays low until it ends, while register writes are taken
// as usual. The aborted thread mask sits at byte address 0 of the APB port and is to be
// written only while no item is in flight. Keys at or above TABLE_KEYS read as an empty
// entry and are never written.
module deterministic_reservation_table_top #(
	parameter int TABLE_KEYS = drt_pkg::TABLE_KEYS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	drt_req_if.sink                           req,
	drt_rsp_if.source                         rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [drt_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [drt_pkg::DATA_W-1:0]   pwdata,
	output logic      [drt_pkg::DATA_W-1:0]   prdata,
	output logic                              pready
);
	import drt_pkg::*;

	localparam int AW = $clog2(TABLE_KEYS);
	localparam int XW = KEY_W + AW + 1;

	// Claim rule: the stored owner keeps the entry against a larger or equal id unless
	// the stored batch is older; an empty entry always yields.
	function automatic logic may_claim(input logic [ID_W-1:0] sid,
	                                   input logic [BATCH_W-1:0] sbatch,
	                                   input logic [ID_W-1:0] tid,
	                                   input logic [BATCH_W-1:0] batch);
		logic keep;
		keep = (sid != '0) && (sbatch == batch) && (sid <= tid);
		return !keep && ((sid == '0) || (sid > tid) || (sbatch < batch));
	endfunction

	// Configuration register.
	logic [MASK_W-1:0] mask_q;
	reg_idx_t          reg_idx;
	logic              cfg_we;

	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == REG_ABORTED_MASK);
	assign prdata  = (reg_idx == REG_ABORTED_MASK) ? mask_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= pwdata;
		end
	end

	// Clearing pass after reset.
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(TABLE_KEYS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Handshake and stage control.
	logic v_s1;
	logic out_free;
	logic adv;
	logic in_acc;
	logic rsp_valid_q;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign adv       = v_s1 && out_free;
	assign req.ready = !clr_busy_q && (!v_s1 || out_free);
	assign in_acc    = req.valid && req.ready;

	// Key decode: widen so that any table depth compares and indexes correctly.
	logic [XW-1:0] key_x;
	logic          in_ok;
	logic [AW-1:0] in_addr;

	assign key_x   = XW'(req.key);
	assign in_ok   = key_x < XW'(TABLE_KEYS);
	assign in_addr = key_x[AW-1:0];

	// Stage 1 holds the item while its entry comes out of the RAM.
	cmd_t                cmd_s1;
	logic [AW-1:0]       addr_s1;
	logic                ok_s1;
	logic [ID_W-1:0]     tid_s1;
	logic [BATCH_W-1:0]  batch_s1;
	logic [THREAD_W-1:0] thr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= cmd_t'(req.cmd);
			addr_s1  <= in_addr;
			ok_s1    <= in_ok;
			tid_s1   <= req.txn_id;
			batch_s1 <= req.batch_num;
			thr_s1   <= req.worker;
		end
	end

	// Entry RAM and write-to-read forwarding.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;
	logic          fwd_hit_q;
	entry_t        fwd_data_q;
	entry_t        cur;
	entry_t        nxt;
	logic          wr_s1;
	logic          reserved_d;
	logic          conflict_d;

	// While stalled the stage re-reads its own key so the RAM output stays current.
	assign ram_raddr = in_acc ? in_addr : addr_s1;
	assign ram_we    = clr_busy_q || (adv && wr_s1);
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? entry_t'('0) : nxt;

	drt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_KEYS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
	end

	// Read-modify-write and the checks.
	always_comb begin
		logic claim;
		logic aborted;
		cur = '0;
		if (ok_s1) begin
			cur = fwd_hit_q ? fwd_data_q : ram_rdata;
		end
		nxt        = cur;
		wr_s1      = 1'b0;
		reserved_d = 1'b0;
		conflict_d = 1'b0;
		claim      = 1'b0;
		aborted    = (32'(cur.w_thread) < 32'(THREADS)) && mask_q[cur.w_thread];
		case (cmd_s1)
			CMD_RESERVE_READ: begin
				claim = may_claim(cur.r_id, cur.r_batch, tid_s1, batch_s1);
				if (claim) begin
					nxt.r_id = tid_s1;
					if (cur.r_batch < batch_s1) begin
						nxt.r_batch = batch_s1;
					end
				end
				wr_s1      = ok_s1 && claim;
				reserved_d = ok_s1 && (nxt.r_id == tid_s1) && (tid_s1 != '0);
			end
			CMD_RESERVE_WRITE: begin
				claim = may_claim(cur.w_id, cur.w_batch, tid_s1, batch_s1);
				if (claim) begin
					nxt.w_id     = tid_s1;
					nxt.w_thread = thr_s1;
					if (cur.w_batch < batch_s1) begin
						nxt.w_batch = batch_s1;
					end
				end
				wr_s1      = ok_s1 && claim;
				reserved_d = ok_s1 && (nxt.w_id == tid_s1) && (tid_s1 != '0);
			end
			CMD_CHECK_WAW: begin
				conflict_d = (cur.w_id != tid_s1) || (cur.w_batch != batch_s1);
			end
			CMD_CHECK_RAW: begin
				conflict_d = (tid_s1 > cur.w_id) && (cur.w_batch == batch_s1) &&
				             (cur.w_id != '0) && !aborted;
			end
			CMD_CHECK_WAR: begin
				conflict_d = (tid_s1 > cur.r_id) && (cur.r_batch == batch_s1) &&
				             (cur.r_id != '0);
			end
			default: begin
				conflict_d = 1'b0;
			end
		endcase
	end

	// Output register.
	logic reserved_q;
	logic conflict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reserved_q <= reserved_d;
			conflict_q <= conflict_d;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.reserved = reserved_q;
	assign rsp.conflict = conflict_q;

endmodule
`default_nettype wire
